/* src/iclm_pkg.sv */
package iclm_pkg;

  // Default pool size and fixed field widths
  localparam int unsigned NODE_COUNT_DEF = 256;
  localparam int unsigned FIELD_W        = 8;
  localparam int unsigned MODE_W         = 3;
  localparam logic [FIELD_W-1:0] SAT_LEN = 8'hff;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ROOT   = 3'd0,
    MODE_AFTER  = 3'd1,
    MODE_BEFORE = 3'd2,
    MODE_UNLINK = 3'd3,
    MODE_LOCATE = 3'd4,
    MODE_COUNT  = 3'd5
  } mode_t;

  // Per-lane write enables of the node RAM
  typedef struct packed {
    logic fwd;
    logic bwd;
    logic head;
  } lane_we_t;

endpackage

/* src/iclm_node_ram.sv */
module iclm_node_ram
  import iclm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  output logic [FIELD_W-1:0]            rd_fwd,
  output logic [FIELD_W-1:0]            rd_bwd,
  output logic [FIELD_W-1:0]            rd_head,
  input  lane_we_t                      wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input  logic [FIELD_W-1:0]            wr_fwd,
  input  logic [FIELD_W-1:0]            wr_bwd,
  input  logic [FIELD_W-1:0]            wr_head
);

  // One word per node: {head, bwd, fwd}, each lane separately writable
  logic [3*FIELD_W-1:0] mem [NODE_COUNT];
  logic [3*FIELD_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en.fwd) begin
      mem[wr_addr][FIELD_W-1:0] <= wr_fwd;
    end
    if (wr_en.bwd) begin
      mem[wr_addr][2*FIELD_W-1:FIELD_W] <= wr_bwd;
    end
    if (wr_en.head) begin
      mem[wr_addr][3*FIELD_W-1:2*FIELD_W] <= wr_head;
    end
    rd_word_r <= mem[rd_addr];
  end

  assign rd_fwd  = rd_word_r[FIELD_W-1:0];
  assign rd_bwd  = rd_word_r[2*FIELD_W-1:FIELD_W];
  assign rd_head = rd_word_r[3*FIELD_W-1:2*FIELD_W];

endmodule

/* src/iclm_ctrl.sv */
module iclm_ctrl
  import iclm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [MODE_W-1:0]             req_mode,
  input  logic [FIELD_W-1:0]            req_anchor,
  input  logic [FIELD_W-1:0]            req_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [FIELD_W-1:0]            res_located,
  output logic [FIELD_W-1:0]            res_length,
  output logic                          res_overrun,
  output logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  input  logic [FIELD_W-1:0]            rd_fwd,
  input  logic [FIELD_W-1:0]            rd_bwd,
  input  logic [FIELD_W-1:0]            rd_head,
  output lane_we_t                      wr_en,
  output logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  output logic [FIELD_W-1:0]            wr_fwd,
  output logic [FIELD_W-1:0]            wr_bwd,
  output logic [FIELD_W-1:0]            wr_head
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam logic [FIELD_W:0]   POOL     = (FIELD_W+1)'(NODE_COUNT);
  localparam logic [IDX_W-1:0]   LAST_STEP = IDX_W'(NODE_COUNT - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_W1   = 6'b000010,
    ST_W2   = 6'b000100,
    ST_W3   = 6'b001000,
    ST_WALK = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [IDX_W-1:0]   anchor_r, anchor_nxt;
  logic [IDX_W-1:0]   item_r, item_nxt;
  logic [IDX_W-1:0]   nxt_r, nxt_nxt;
  logic [IDX_W-1:0]   prv_r, prv_nxt;
  logic [FIELD_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [FIELD_W-1:0] located_r, located_nxt;
  logic [FIELD_W-1:0] length_r, length_nxt;
  logic               overrun_r, overrun_nxt;

  logic               anchor_ok, item_ok, req_ok;
  logic [IDX_W-1:0]   fwd_fix, bwd_fix;
  logic               walk_hit;

  // Stored links outside the pool read as node zero
  assign fwd_fix = ({1'b0, rd_fwd} < POOL) ? rd_fwd[IDX_W-1:0] : '0;
  assign bwd_fix = ({1'b0, rd_bwd} < POOL) ? rd_bwd[IDX_W-1:0] : '0;

  assign anchor_ok = ({1'b0, req_anchor} < POOL);
  assign item_ok   = ({1'b0, req_item} < POOL);

  always_comb begin
    case (req_mode)
      MODE_ROOT, MODE_UNLINK:             req_ok = item_ok;
      MODE_AFTER, MODE_BEFORE, MODE_LOCATE: req_ok = anchor_ok && item_ok;
      MODE_COUNT:                         req_ok = anchor_ok;
      default:                            req_ok = 1'b0;
    endcase
  end

  assign walk_hit = (fwd_fix == anchor_r) || ((mode_r == MODE_LOCATE) && (fwd_fix == item_r));

  assign req_ready   = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign res_located = located_r;
  assign res_length  = length_r;
  assign res_overrun = overrun_r;

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    anchor_nxt  = anchor_r;
    item_nxt    = item_r;
    nxt_nxt     = nxt_r;
    prv_nxt     = prv_r;
    root_nxt    = root_r;
    step_nxt    = step_r;
    located_nxt = located_r;
    length_nxt  = length_r;
    overrun_nxt = overrun_r;
    rd_addr     = fwd_fix;
    wr_en       = '0;
    wr_addr     = item_r;
    wr_fwd      = FIELD_W'(item_r);
    wr_bwd      = FIELD_W'(item_r);
    wr_head     = FIELD_W'(item_r);

    case (state_r)
      ST_IDLE: begin
        rd_addr = (req_mode == MODE_UNLINK) ? req_item[IDX_W-1:0] : req_anchor[IDX_W-1:0];
        if (req_valid) begin
          mode_nxt    = mode_t'(req_mode);
          anchor_nxt  = req_anchor[IDX_W-1:0];
          item_nxt    = req_item[IDX_W-1:0];
          step_nxt    = '0;
          located_nxt = '0;
          length_nxt  = '0;
          overrun_nxt = 1'b0;
          if (!req_ok) begin
            state_nxt = ST_DONE;
          end else if (req_mode == MODE_LOCATE || req_mode == MODE_COUNT) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_W1;
          end
        end
      end

      ST_W1: begin
        // Read data of the anchor (or item for unlink) is valid now
        nxt_nxt   = fwd_fix;
        prv_nxt   = bwd_fix;
        root_nxt  = rd_head;
        state_nxt = ST_W2;
        case (mode_r)
          MODE_ROOT: begin
            wr_en     = '{fwd: 1'b1, bwd: 1'b1, head: 1'b1};
            state_nxt = ST_DONE;
          end
          MODE_AFTER: begin
            wr_en   = '{fwd: 1'b1, bwd: 1'b0, head: 1'b0};
            wr_addr = anchor_r;
          end
          MODE_BEFORE: begin
            wr_en   = '{fwd: 1'b0, bwd: 1'b1, head: 1'b0};
            wr_addr = anchor_r;
          end
          MODE_UNLINK: begin
            if (fwd_fix == item_r) begin
              state_nxt = ST_DONE;
            end else begin
              wr_en = '{fwd: 1'b1, bwd: 1'b1, head: 1'b1};
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_W2: begin
        state_nxt = ST_W3;
        case (mode_r)
          MODE_AFTER: begin
            wr_en   = '{fwd: 1'b1, bwd: 1'b1, head: 1'b1};
            wr_fwd  = FIELD_W'(nxt_r);
            wr_bwd  = FIELD_W'(anchor_r);
            wr_head = root_r;
          end
          MODE_BEFORE: begin
            wr_en   = '{fwd: 1'b1, bwd: 1'b1, head: 1'b1};
            wr_fwd  = FIELD_W'(anchor_r);
            wr_bwd  = FIELD_W'(prv_r);
            wr_head = root_r;
          end
          MODE_UNLINK: begin
            wr_en   = '{fwd: 1'b1, bwd: 1'b0, head: 1'b0};
            wr_addr = prv_r;
            wr_fwd  = FIELD_W'(nxt_r);
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_W3: begin
        state_nxt = ST_DONE;
        case (mode_r)
          MODE_AFTER: begin
            wr_en   = '{fwd: 1'b0, bwd: 1'b1, head: 1'b0};
            wr_addr = nxt_r;
          end
          MODE_BEFORE: begin
            wr_en   = '{fwd: 1'b1, bwd: 1'b0, head: 1'b0};
            wr_addr = prv_r;
          end
          MODE_UNLINK: begin
            wr_en   = '{fwd: 1'b0, bwd: 1'b1, head: 1'b0};
            wr_addr = nxt_r;
            wr_bwd  = FIELD_W'(prv_r);
          end
          default: begin
          end
        endcase
      end

      ST_WALK: begin
        // One link per cycle; the read of the next node is issued from fwd_fix
        if (walk_hit) begin
          located_nxt = (mode_r == MODE_LOCATE) ? FIELD_W'(fwd_fix) : '0;
          length_nxt  = (mode_r == MODE_COUNT) ? FIELD_W'(step_r) : '0;
          state_nxt   = ST_DONE;
        end else if (step_r == LAST_STEP) begin
          located_nxt = (mode_r == MODE_LOCATE) ? FIELD_W'(anchor_r) : '0;
          length_nxt  = (mode_r == MODE_COUNT) ? SAT_LEN : '0;
          overrun_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mode_r    <= mode_nxt;
    anchor_r  <= anchor_nxt;
    item_r    <= item_nxt;
    nxt_r     <= nxt_nxt;
    prv_r     <= prv_nxt;
    root_r    <= root_nxt;
    step_r    <= step_nxt;
    located_r <= located_nxt;
    length_r  <= length_nxt;
    overrun_r <= overrun_nxt;
  end

endmodule

/* src/indexed_circular_list_manager.sv */
// Pool of NODE_COUNT nodes forming circular doubly linked lists. Each node
// holds a forward link, a backward link and its list's root, all kept in one
// single-port-write RAM with a registered read (lanes written separately).
// One request is handled at a time; the next request is taken while the
// previous result still waits in the output register. Make root writes all
// lanes of the item's entry; insert and unlink do one RAM read, then up to
// three single-entry writes, and an unlink of a lone node writes nothing.
// Locate and count walk the forward links one node per cycle; a walk that
// reaches NODE_COUNT checks without meeting the anchor (or the sought item)
// stops and raises walk_overrun, with a count's length saturated to 0xff.
// Requests with an index that their mode uses at or above NODE_COUNT, or an
// unused mode, change nothing and return zeros. Node entries are undefined
// after reset: a node must be made a root before any request reads it.
// There is no reset sweep.
module indexed_circular_list_manager
  import iclm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[2:0], anchor_index[10:3], item_index[18:11], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // located_index[7:0], list_length[15:8], walk_overrun[16], pad
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);

  logic [MODE_W-1:0]  in_mode;
  logic [FIELD_W-1:0] in_anchor_index;
  logic [FIELD_W-1:0] in_item_index;

  logic               res_valid, res_ready;
  logic [FIELD_W-1:0] res_located, res_length;
  logic               res_overrun;

  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [FIELD_W-1:0] rd_fwd, rd_bwd, rd_head;
  logic [FIELD_W-1:0] wr_fwd, wr_bwd, wr_head;
  lane_we_t           wr_en;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_located_r, out_length_r;
  logic               out_overrun_r;

  // Unpack the input item
  assign in_mode         = in_tdata[2:0];
  assign in_anchor_index = in_tdata[10:3];
  assign in_item_index   = in_tdata[18:11];

  iclm_ctrl #(
    .NODE_COUNT(NODE_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_mode   (in_mode),
    .req_anchor (in_anchor_index),
    .req_item   (in_item_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_located(res_located),
    .res_length (res_length),
    .res_overrun(res_overrun),
    .rd_addr    (rd_addr),
    .rd_fwd     (rd_fwd),
    .rd_bwd     (rd_bwd),
    .rd_head    (rd_head),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_fwd     (wr_fwd),
    .wr_bwd     (wr_bwd),
    .wr_head    (wr_head)
  );

  iclm_node_ram #(
    .NODE_COUNT(NODE_COUNT)
  ) u_ram (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_fwd (rd_fwd),
    .rd_bwd (rd_bwd),
    .rd_head(rd_head),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_fwd (wr_fwd),
    .wr_bwd (wr_bwd),
    .wr_head(wr_head)
  );

  // Output register: load a finished result whenever the slot is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_located_r <= res_located;
      out_length_r  <= res_length;
      out_overrun_r <= res_overrun;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_overrun_r, out_length_r, out_located_r};

  // The sequencer never takes a request while holding a result
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && res_valid))
    else $error("request taken while a result is pending");

  // A result handed to the output register shows up as a valid item
  assert property (@(posedge clk) disable iff (!rst_n) (res_valid && res_ready) |=> out_tvalid)
    else $error("result lost on its way to the output register");

  // Overrun comes only from a walk: count saturates, locate reports zero length
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |->
      ((out_tdata[15:8] == SAT_LEN && out_tdata[7:0] == '0) || out_tdata[15:8] == '0))
    else $error("inconsistent overrun result");

endmodule
